@@ src/tcw_pkg.sv @@
package tcw_pkg;

    localparam int DEF_COLS = 80;
    localparam int DEF_ROWS = 25;

    localparam logic [7:0] RESET_ATTR   = 8'd7;
    localparam logic [7:0] BLANK_CHAR   = 8'h20;
    localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef struct packed {
        logic       opcode;
        logic [7:0] character;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } t_cmd;

    typedef struct packed {
        logic [4:0] cursor_row;
        logic [6:0] cursor_col;
        logic [7:0] cell_char;
        logic [7:0] cell_attr;
        logic       scrolled;
    } t_result;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SCROLL
    } t_state;

endpackage

@@ src/tcw_ram.sv @@
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ src/text_console_writer.sv @@
// a put without scroll gives its result in the cycle after the transfer, busy stays low
// a read passes through ST_READ (registered read), then the done register gives its result; busy is high in ST_READ
// a put that scrolls holds busy high through ST_SCROLL, one cell written per cycle through
// the single write port of the screen memory; its result shows as busy falls
// reset: cursor to 0, attribute 7, then a clearing pass over all ROWS*COLS cells with busy high
// results cannot be stalled by the receiver
module text_console_writer #(
    parameter int COLS = tcw_pkg::DEF_COLS,
    parameter int ROWS = tcw_pkg::DEF_ROWS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  tcw_pkg::t_cmd    i_cmd,
    output logic             o_done,
    output tcw_pkg::t_result o_result,
    input  logic             i_cfg_wr_en,
    input  logic [7:0]       i_cfg_wr_data
);

    import tcw_pkg::*;

    localparam int CW    = $clog2(COLS);
    localparam int RW    = $clog2(ROWS);
    localparam int CELLS = ROWS * COLS;
    localparam int AW    = $clog2(CELLS);
    localparam int NW    = $clog2(CELLS + 1);
    localparam int MOVED = (ROWS - 1) * COLS;

    t_state          r_state, n_state;
    logic [NW-1:0]   r_cnt, n_cnt;
    logic [CW-1:0]   r_col, n_col;
    logic [RW-1:0]   r_line, n_line;
    logic [AW-1:0]   r_pos, n_pos;
    logic            r_rd_ok, n_rd_ok;
    logic            r_done, n_done;
    t_result         r_result, n_result;
    logic [7:0]      r_attr;

    logic            mem_we;
    logic [AW-1:0]   mem_wr_addr;
    logic [15:0]     mem_wr_data;
    logic [AW-1:0]   mem_rd_addr;
    logic [15:0]     mem_rd_data;

    logic            in_range;
    logic [31:0]     rd_addr_wide;
    logic [31:0]     src_wide;
    logic [31:0]     dst_wide;
    logic [31:0]     line_start_wide;
    logic [31:0]     row_wide;
    logic [31:0]     col_wide;
    logic [15:0]     rd_cell;
    logic            scr;
    logic            line_inc;

    tcw_ram #(
        .WIDTH(16),
        .DEPTH(CELLS)
    ) u_screen (
        .i_clk     (i_clk),
        .i_wr_en   (mem_we),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    assign in_range = (32'(i_cmd.read_row) < 32'(ROWS)) && (32'(i_cmd.read_col) < 32'(COLS));
    assign rd_addr_wide = 32'(i_cmd.read_row) * 32'(COLS) + 32'(i_cmd.read_col);
    assign src_wide = 32'(r_cnt) + 32'(COLS);
    assign dst_wide = 32'(r_cnt) - 32'd1;
    assign line_start_wide = 32'(r_pos) - 32'(r_col) + 32'(COLS);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_col       = r_col;
        n_line      = r_line;
        n_pos       = r_pos;
        n_rd_ok     = r_rd_ok;
        n_done      = 1'b0;
        n_result    = r_result;
        mem_we      = 1'b0;
        mem_wr_addr = r_pos;
        mem_wr_data = {r_attr, i_cmd.character};
        mem_rd_addr = in_range ? rd_addr_wide[AW-1:0] : '0;
        rd_cell     = '0;
        scr         = 1'b0;
        line_inc    = 1'b0;

        case (r_state)
            ST_CLEAR: begin
                mem_we      = 1'b1;
                mem_wr_addr = r_cnt[AW-1:0];
                mem_wr_data = '0;
                if (r_cnt == NW'(CELLS - 1)) begin
                    n_cnt   = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_cnt = r_cnt + NW'(1);
                end
            end
            ST_IDLE: begin
                if (start) begin
                    if (i_cmd.opcode == OP_READ) begin
                        n_rd_ok = in_range;
                        n_state = ST_READ;
                    end else begin
                        if (i_cmd.character == NEWLINE_CHAR) begin
                            n_col    = '0;
                            n_pos    = line_start_wide[AW-1:0];
                            line_inc = 1'b1;
                        end else begin
                            mem_we = 1'b1;
                            n_pos  = r_pos + AW'(1);
                            if (r_col == CW'(COLS - 1)) begin
                                n_col    = '0;
                                line_inc = 1'b1;
                            end else begin
                                n_col = r_col + CW'(1);
                            end
                        end
                        if (line_inc && r_line == RW'(ROWS - 1)) begin
                            // cursor parks at the start of the last row, screen moves up
                            n_pos   = AW'(MOVED);
                            n_cnt   = '0;
                            n_state = ST_SCROLL;
                        end else begin
                            if (line_inc) begin
                                n_line = r_line + RW'(1);
                            end
                            n_done = 1'b1;
                        end
                    end
                end
            end
            ST_READ: begin
                rd_cell = r_rd_ok ? mem_rd_data : '0;
                n_done  = 1'b1;
                n_state = ST_IDLE;
            end
            ST_SCROLL: begin
                // read address is COLS + 1 cells past the write address; each write takes the cell COLS further on
                mem_rd_addr = (src_wide < 32'(CELLS)) ? src_wide[AW-1:0] : '0;
                mem_wr_addr = dst_wide[AW-1:0];
                mem_wr_data = (dst_wide < 32'(MOVED)) ? mem_rd_data : {r_attr, BLANK_CHAR};
                mem_we      = (r_cnt != '0);
                if (r_cnt == NW'(CELLS)) begin
                    scr     = 1'b1;
                    n_done  = 1'b1;
                    n_cnt   = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_cnt = r_cnt + NW'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        row_wide = 32'(n_line);
        col_wide = 32'(n_col);
        if (n_done) begin
            n_result.cursor_row = row_wide[4:0];
            n_result.cursor_col = col_wide[6:0];
            n_result.cell_char  = rd_cell[7:0];
            n_result.cell_attr  = rd_cell[15:8];
            n_result.scrolled   = scr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_cnt   <= '0;
            r_col   <= '0;
            r_line  <= '0;
            r_pos   <= '0;
            r_rd_ok <= 1'b0;
            r_done  <= 1'b0;
            r_attr  <= RESET_ATTR;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_col   <= n_col;
            r_line  <= n_line;
            r_pos   <= n_pos;
            r_rd_ok <= n_rd_ok;
            r_done  <= n_done;
            if (i_cfg_wr_en) begin
                r_attr <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

    a_pos_matches_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_pos) == 32'(r_line) * 32'(COLS) + 32'(r_col))
        else $error("cursor address out of step with row and column");

    a_cursor_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_line) < 32'(ROWS)) && (32'(r_col) < 32'(COLS)))
        else $error("cursor outside the screen");

    a_scroll_parks_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.scrolled) |-> (r_line == RW'(ROWS - 1) && r_col == '0))
        else $error("scroll did not leave cursor at start of last row");

    a_done_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(r_state) != ST_CLEAR))
        else $error("result transfer during clearing pass");

endmodule
